@@ hw/rtl/ph_trimmed_mean_calibrator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pH calibrator
// Shared concurrent-check forms; the including module supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef PH_TRIMMED_MEAN_CALIBRATOR_ASSERT_SVH
`define PH_TRIMMED_MEAN_CALIBRATOR_ASSERT_SVH

// Same-cycle implication.
`define PTM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptm_pkg
// Types, constants and command/status bundles of the trimmed-mean pH
// calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

  localparam int ADC_BITS_DEF = 15;

  localparam int CODE_W   = 15;
  localparam int SAMPLE_W = 16;
  localparam int VREF_W   = 13;
  localparam int FS_W     = 16;
  localparam int UV_W     = 23;
  localparam int PH_W     = 18;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  // Shared divider: 38-bit dividend, 24-bit divisor, one quotient bit a cycle
  localparam int DIV_W  = 38;
  localparam int DSR_W  = 24;
  localparam int DCNT_W = 6;

  localparam logic [VREF_W-1:0] VREF_RST = 13'd4096;
  localparam logic [FS_W-1:0]   FS_RST   = 16'd32767;

  localparam logic [UV_W-1:0]   UV_MAX    = 23'd8000000;
  localparam logic [9:0]        MV_TO_UV  = 10'd1000;
  localparam logic [11:0]       RISE_LO   = 12'd2860;
  localparam logic [11:0]       RISE_HI   = 12'd2140;
  localparam logic signed [39:0] BASE_LO  = 40'sd4000;
  localparam logic signed [39:0] BASE_HI  = 40'sd6860;
  localparam logic signed [39:0] PH_LIMIT = 40'sd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VREF   = 3'd0,
    REG_FS     = 3'd1,
    REG_CAL4   = 3'd2,
    REG_CAL686 = 3'd3,
    REG_CAL9   = 3'd4
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_UNCAL = 2'd1,
    STAT_DEGEN = 2'd2
  } ph_stat_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_MEAN,
    ST_MUL_V,
    ST_MUL_K,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_SAT,
    ST_SEG,
    ST_MUL_R,
    ST_PDIV_GO,
    ST_PDIV_WAIT,
    ST_PH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept_en;
    logic calc_mean;
    logic mul_volt;
    logic mul_scale;
    logic div_start;
    logic div_sel_ph;
    logic sat_volt;
    logic seg_eval;
    logic mul_rise;
    logic ph_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic group_done;
    logic div_done;
    logic seg_ok;
    logic out_free;
  } sts_t;

endpackage : ptm_pkg

`default_nettype wire

@@ hw/rtl/ptm_div.sv @@
// ----------------------------------------------------------------------------
// ptm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_div
  import ptm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out the top and the quotient bits in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

endmodule : ptm_div

`default_nettype wire

@@ hw/rtl/ptm_datapath.sv @@
// ----------------------------------------------------------------------------
// ptm_datapath
// Config registers, sample window, trimmed mean, voltage scaling, segment
// mapping, pH calculation, the shared divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ph_trimmed_mean_calibrator_assert.svh"

module ptm_datapath
  import ptm_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
)
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CODE_W-1:0]           out_mean_code,
  output logic [UV_W-1:0]             out_voltage_uv,
  output logic signed [PH_W-1:0]      out_ph_milli,
  output logic [STAT_W-1:0]           out_status
);

  localparam logic [CODE_W-1:0] CODE_TOP =
    (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << ADC_BITS) - 1);

  // configuration
  logic [VREF_W-1:0] vref_r;
  logic [FS_W-1:0]   fs_r;
  logic [UV_W-1:0]   cal4_r;
  logic [UV_W-1:0]   cal686_r;
  logic [UV_W-1:0]   cal9_r;

  // window
  logic [CODE_W-1:0] win_r [4];
  logic [1:0]        fill_r;
  logic              take;
  logic [CODE_W-1:0] code_in;

  // mean
  logic [CODE_W-1:0] mx01, mn01, mx23, mn23, mx_all, mn_all;
  logic [CODE_W+1:0] sum_all;
  logic [CODE_W+1:0] mid_sum;
  logic [CODE_W-1:0] mean_r;

  // arithmetic
  logic [DIV_W-1:0]  prod_r;
  logic [27:0]       mv_prod;
  logic [UV_W-1:0]   uv_r;
  logic [FS_W-1:0]   fs_eff;

  // segment
  logic              uncal;
  logic              lower;
  logic [UV_W-1:0]   seg_lo, seg_hi;
  logic signed [UV_W:0] diff, span;
  logic [UV_W:0]     diff_abs, span_abs;
  ph_stat_t          seg_stat;
  ph_stat_t          stat_r;
  logic              lower_r;
  logic              neg_r;
  logic [UV_W-1:0]   mag_r;
  logic [UV_W-1:0]   span_r;
  logic [11:0]       rise;

  // pH
  logic signed [39:0] q_ext, q_signed, ph_sum;
  logic signed [PH_W-1:0] ph_sat;
  logic signed [PH_W-1:0] ph_r;

  // divider
  logic              div_busy, div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [DIV_W-1:0]  div_dvd;
  logic [DSR_W-1:0]  div_dsr;

  // output
  logic              out_valid_r;
  logic [CODE_W-1:0] out_mean_r;
  logic [UV_W-1:0]   out_uv_r;
  logic signed [PH_W-1:0] out_ph_r;
  logic [STAT_W-1:0] out_stat_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r   <= VREF_RST;
      fs_r     <= FS_RST;
      cal4_r   <= '0;
      cal686_r <= '0;
      cal9_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VREF:   vref_r   <= cfg_data[VREF_W-1:0];
        REG_FS:     fs_r     <= cfg_data[FS_W-1:0];
        REG_CAL4:   cal4_r   <= cfg_data;
        REG_CAL686: cal686_r <= cfg_data;
        REG_CAL9:   cal9_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- window ----------------
  assign take = cmd.accept_en && in_valid;

  always_comb begin
    if (in_sample[SAMPLE_W-1]) begin
      code_in = '0;
    end else if (in_sample[CODE_W-1:0] > CODE_TOP) begin
      code_in = CODE_TOP;
    end else begin
      code_in = in_sample[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (take) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win_r[fill_r] <= code_in;
    end
  end

  // Middle two of four: total minus largest minus smallest.
  assign mx01    = (win_r[0] > win_r[1]) ? win_r[0] : win_r[1];
  assign mn01    = (win_r[0] > win_r[1]) ? win_r[1] : win_r[0];
  assign mx23    = (win_r[2] > win_r[3]) ? win_r[2] : win_r[3];
  assign mn23    = (win_r[2] > win_r[3]) ? win_r[3] : win_r[2];
  assign mx_all  = (mx01 > mx23) ? mx01 : mx23;
  assign mn_all  = (mn01 < mn23) ? mn01 : mn23;
  assign sum_all = {2'b0, win_r[0]} + {2'b0, win_r[1]} + {2'b0, win_r[2]}
                 + {2'b0, win_r[3]};
  assign mid_sum = sum_all - {2'b0, mx_all} - {2'b0, mn_all};

  // ---------------- voltage ----------------
  assign mv_prod = {13'b0, mean_r} * {15'b0, vref_r};
  assign fs_eff  = (fs_r == '0) ? FS_W'(1) : fs_r;

  // ---------------- segment ----------------
  assign uncal  = (cal4_r == '0) || (cal686_r == '0) || (cal9_r == '0);
  assign lower  = (uv_r < cal686_r);
  assign seg_lo = lower ? cal4_r : cal686_r;
  assign seg_hi = lower ? cal686_r : cal9_r;
  assign diff   = $signed({1'b0, uv_r}) - $signed({1'b0, seg_lo});
  assign span   = $signed({1'b0, seg_hi}) - $signed({1'b0, seg_lo});
  assign diff_abs = diff[UV_W] ? (UV_W+1)'(-diff) : diff;
  assign span_abs = span[UV_W] ? (UV_W+1)'(-span) : span;

  always_comb begin
    if (uncal) begin
      seg_stat = STAT_UNCAL;
    end else if (span == '0) begin
      seg_stat = STAT_DEGEN;
    end else begin
      seg_stat = STAT_OK;
    end
  end

  assign rise = lower_r ? RISE_LO : RISE_HI;

  // ---------------- pH ----------------
  assign q_ext    = {2'b0, div_quot};
  assign q_signed = neg_r ? -q_ext : q_ext;
  assign ph_sum   = (lower_r ? BASE_LO : BASE_HI) + q_signed;

  always_comb begin
    if (ph_sum > PH_LIMIT) begin
      ph_sat = PH_W'(PH_LIMIT);
    end else if (ph_sum < -PH_LIMIT) begin
      ph_sat = PH_W'(-PH_LIMIT);
    end else begin
      ph_sat = ph_sum[PH_W-1:0];
    end
  end

  // ---------------- shared divider ----------------
  assign div_dvd = cmd.div_sel_ph ? prod_r : prod_r;
  assign div_dsr = cmd.div_sel_ph ? {1'b0, span_r} : {{(DSR_W-FS_W){1'b0}}, fs_eff};

  ptm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.calc_mean) begin
      mean_r <= mid_sum[CODE_W:1];
    end
    if (cmd.mul_volt) begin
      prod_r <= {10'b0, mv_prod};
    end else if (cmd.mul_scale) begin
      prod_r <= {10'b0, prod_r[27:0]} * {28'b0, MV_TO_UV};
    end else if (cmd.mul_rise) begin
      prod_r <= {15'b0, mag_r} * {26'b0, rise};
    end
    if (cmd.sat_volt) begin
      uv_r <= (div_quot > {15'b0, UV_MAX}) ? UV_MAX : div_quot[UV_W-1:0];
    end
    if (cmd.seg_eval) begin
      stat_r  <= seg_stat;
      lower_r <= lower;
      neg_r   <= diff[UV_W] ^ span[UV_W];
      mag_r   <= diff_abs[UV_W-1:0];
      span_r  <= span_abs[UV_W-1:0];
    end
    if (cmd.ph_calc) begin
      ph_r <= ph_sat;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mean_r <= mean_r;
      out_uv_r   <= uv_r;
      out_ph_r   <= (stat_r == STAT_OK) ? ph_r : '0;
      out_stat_r <= stat_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_code  = out_mean_r;
  assign out_voltage_uv = out_uv_r;
  assign out_ph_milli   = out_ph_r;
  assign out_status     = out_stat_r;

  assign sts.group_done = take && (fill_r == 2'd3);
  assign sts.div_done   = div_done;
  assign sts.seg_ok     = (seg_stat == STAT_OK);
  assign sts.out_free   = !out_valid_r || !out_stall;

  `PTM_ASSERT(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")
  `PTM_ASSERT(a_out_free, cmd.out_load, !out_valid_r || !out_stall, "result overwritten")
  `PTM_ASSERT_NEXT(a_uv_sat, cmd.sat_volt, uv_r <= UV_MAX, "voltage above saturation")
  `PTM_ASSERT_NEXT(a_ph_sat, cmd.ph_calc,
    (ph_r <= PH_W'(PH_LIMIT)) && (ph_r >= PH_W'(-PH_LIMIT)), "pH outside limit")

endmodule : ptm_datapath

`default_nettype wire

@@ hw/rtl/ptm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer: gathers a group, then steps the datapath through mean, voltage
// division, segment selection, pH division (skipped unless the segment is valid) and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_ctrl
  import ptm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_FILL: begin
        cmd.accept_en = 1'b1;
        if (sts.group_done) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cmd.calc_mean = 1'b1;
        state_nxt     = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd.mul_volt = 1'b1;
        state_nxt    = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd.mul_scale = 1'b1;
        state_nxt     = ST_VDIV_GO;
      end
      ST_VDIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_VDIV_WAIT;
      end
      ST_VDIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.sat_volt = 1'b1;
        state_nxt    = ST_SEG;
      end
      ST_SEG: begin
        cmd.seg_eval = 1'b1;
        // skip the pH division when uncalibrated or the span is zero
        state_nxt    = sts.seg_ok ? ST_MUL_R : ST_OUT;
      end
      ST_MUL_R: begin
        cmd.mul_rise = 1'b1;
        state_nxt    = ST_PDIV_GO;
      end
      ST_PDIV_GO: begin
        cmd.div_start  = 1'b1;
        cmd.div_sel_ph = 1'b1;
        state_nxt      = ST_PDIV_WAIT;
      end
      ST_PDIV_WAIT: begin
        cmd.div_sel_ph = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_PH;
        end
      end
      ST_PH: begin
        cmd.ph_calc = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

endmodule : ptm_ctrl

`default_nettype wire

@@ hw/rtl/ph_trimmed_mean_calibrator.sv @@
// ----------------------------------------------------------------------------
// ph_trimmed_mean_calibrator
// Usage: converter codes enter on in_sample (in_valid/in_stall), one transfer
//   each. Every fourth transfer closes a group: the middle two of the four
//   clamped codes are averaged, scaled to microvolts and mapped to pH x1000
//   on the 4..6.86 or 6.86..9 calibration line.
// Result: one transfer on out_* (out_valid/out_stall) per group, carrying
//   mean_code, voltage_uv, ph_milli and status.
// Processing: after the fourth sample the shared serial divider runs twice
//   (once when the pH step is skipped) before the result is loaded. In_stall
//   stays high from the fourth sample until the result is loaded, so no new
//   sample is taken while a group is being worked out.
// Stall: the result sits in an output register; the next group is gathered
//   while it waits, and only the next result load waits for it to drain.
// Config: cfg_valid/cfg_ready with cfg_index/cfg_data, always ready; write
//   only while idle. Indexes above four are ignored.
// Reset: rst_n (synchronous, low) empties the group, drops out_valid and
//   restores vref 4096 mV, full scale 32767 and cleared calibration points.
// ----------------------------------------------------------------------------
`default_nettype none

module ph_trimmed_mean_calibrator
  import ptm_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
)
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [CODE_W-1:0]               out_mean_code,
  output logic [UV_W-1:0]                 out_voltage_uv,
  output logic signed [PH_W-1:0]          out_ph_milli,
  output logic [STAT_W-1:0]               out_status
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.accept_en;

  ptm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ptm_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_code  (out_mean_code),
    .out_voltage_uv (out_voltage_uv),
    .out_ph_milli   (out_ph_milli),
    .out_status     (out_status)
  );

endmodule : ph_trimmed_mean_calibrator

`default_nettype wire

@@ tb/sv/ph_trimmed_mean_calibrator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ph_trimmed_mean_calibrator_test
// Feeds converter codes in groups of four and checks every group result
// (trimmed mean, microvolts, pH x1000, status) against a local calculation
// of the same chain or, for typed table rows, the value in the table. A short
// stimulus table covers reset, clamping, saturation and the error statuses.
// Random groups follow, run over eight register settings and four flow-control mixes on both channels.
// ----------------------------------------------------------------------------

module ph_trimmed_mean_calibrator_test;
  import ptm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 200;
  localparam int PHASES         = 8;
  localparam int GROUPS_PER_PHASE = 48;
  localparam int NROWS          = 19;

  localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP_UNUSED   = 3'd7;

  localparam longint LO_BASE = 4000;
  localparam longint LO_RISE = 2860;
  localparam longint HI_BASE = 6860;
  localparam longint HI_RISE = 2140;
  localparam longint PH_SAT  = 100000;
  localparam longint UV_SAT  = 8000000;

  typedef struct packed {
    logic [CODE_W-1:0]       mean;
    logic [UV_W-1:0]         uv;
    logic signed [PH_W-1:0]  ph;
    ph_stat_t                st;
  } ph_result_t;

  typedef struct packed {
    logic                      is_cfg;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
    logic [3:0][SAMPLE_W-1:0]  smp;
    logic                      typed;
    ph_result_t                want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NROWS] = '{
    '{1'b0, REG_VREF, 23'd0, '{16'h8000, 16'hFFFF, 16'h0000, 16'h8000},
      1'b1, '{15'd0, 23'd0, 18'sd0, STAT_UNCAL}},
    '{1'b1, REG_VREF, 23'd8191, '0, 1'b0, '0},
    '{1'b1, REG_FS, 23'd0, '0, 1'b0, '0},
    '{1'b0, REG_VREF, 23'd0, '{16'h7FFF, 16'h0001, 16'h7FFF, 16'h0000},
      1'b1, '{15'd16384, 23'd8000000, 18'sd0, STAT_UNCAL}},
    '{1'b1, IDX_TOP_UNUSED, 23'h7FFFFF, '0, 1'b0, '0},
    '{1'b1, REG_VREF, 23'd1000, '0, 1'b0, '0},
    '{1'b1, REG_FS, 23'd1000, '0, 1'b0, '0},
    '{1'b1, REG_CAL4, 23'd2000000, '0, 1'b0, '0},
    '{1'b1, REG_CAL686, 23'd2000000, '0, 1'b0, '0},
    '{1'b1, REG_CAL9, 23'd4000000, '0, 1'b0, '0},
    '{1'b0, REG_VREF, 23'd0, '{16'd1000, 16'd1000, 16'd1000, 16'd1000},
      1'b1, '{15'd1000, 23'd1000000, 18'sd0, STAT_DEGEN}},
    // low line has zero span, but the high line is chosen
    '{1'b0, REG_VREF, 23'd0, '{16'd3000, 16'd2999, 16'd3001, 16'd3000},
      1'b0, '0},
    '{1'b1, REG_CAL686, 23'd4000000, '0, 1'b0, '0},
    '{1'b0, REG_VREF, 23'd0, '{16'd5000, 16'd5000, 16'd5000, 16'd5000},
      1'b1, '{15'd5000, 23'd5000000, 18'sd0, STAT_DEGEN}},
    '{1'b1, REG_CAL4, 23'd8388606, '0, 1'b0, '0},
    '{1'b1, REG_CAL686, 23'd8388607, '0, 1'b0, '0},
    '{1'b0, REG_VREF, 23'd0, '{16'd0, 16'h8001, 16'd0, 16'd0},
      1'b1, '{15'd0, 23'd0, -18'sd100000, STAT_OK}},
    '{1'b1, REG_CAL4, 23'd8388607, '0, 1'b0, '0},
    '{1'b1, REG_CAL686, 23'd8388606, '0, 1'b0, '0}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic [CODE_W-1:0]       out_mean_code;
  logic [UV_W-1:0]         out_voltage_uv;
  logic signed [PH_W-1:0]  out_ph_milli;
  logic [STAT_W-1:0]       out_status;

  // local copy of the registers and the group being gathered
  logic [VREF_W-1:0]  vref_mv_m;
  logic [FS_W-1:0]    full_scale_m;
  logic [UV_W-1:0]    cal4_m;
  logic [UV_W-1:0]    cal686_m;
  logic [UV_W-1:0]    cal9_m;
  logic [CODE_W-1:0]  grp_codes [4];
  logic [1:0]         grp_fill;

  ph_result_t pending_ph [$];
  ph_result_t typed_want;
  bit         use_typed;
  bit         in_busy;
  bit         cfg_busy;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         center_top;
  int         fail_count;
  int         n_samples;
  int         n_checked;
  int         n_writes;
  int         idle_cycles;

  ph_trimmed_mean_calibrator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_code  (out_mean_code),
    .out_voltage_uv (out_voltage_uv),
    .out_ph_milli   (out_ph_milli),
    .out_status     (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one code; on the fourth, work out the group result.
  function automatic bit gather_code(input logic [SAMPLE_W-1:0] s,
                                     output ph_result_t r);
    logic [CODE_W-1:0] srt [4];
    logic [CODE_W-1:0] t;
    longint top_code, code, mean, fsd, uv, ph, lo, hi;
    top_code = (longint'(1) << ADC_BITS_DEF) - 1;
    if (top_code > 32767) top_code = 32767;
    code = s[SAMPLE_W-1] ? 0 : longint'(s[CODE_W-1:0]);
    if (code > top_code) code = top_code;
    grp_codes[grp_fill] = code[CODE_W-1:0];
    grp_fill = grp_fill + 2'd1;
    r = '0;
    if (grp_fill != 2'd0) return 1'b0;

    srt = grp_codes;
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        if (srt[i] > srt[j]) begin
          t = srt[i];
          srt[i] = srt[j];
          srt[j] = t;
        end
    mean = (longint'(srt[1]) + longint'(srt[2])) >> 1;
    fsd = (full_scale_m == 0) ? 1 : longint'(full_scale_m);
    uv = mean * longint'(vref_mv_m) * 1000 / fsd;
    if (uv > UV_SAT) uv = UV_SAT;
    ph = 0;
    if (cal4_m == 0 || cal686_m == 0 || cal9_m == 0) begin
      r.st = STAT_UNCAL;
    end else begin
      if (uv < longint'(cal686_m)) begin
        lo = cal4_m;
        hi = cal686_m;
      end else begin
        lo = cal686_m;
        hi = cal9_m;
      end
      if (lo == hi) begin
        r.st = STAT_DEGEN;
      end else begin
        r.st = STAT_OK;
        if (uv < longint'(cal686_m)) ph = LO_BASE + LO_RISE * (uv - lo) / (hi - lo);
        else ph = HI_BASE + HI_RISE * (uv - lo) / (hi - lo);
        if (ph > PH_SAT) ph = PH_SAT;
        if (ph < -PH_SAT) ph = -PH_SAT;
      end
    end
    r.mean = mean[CODE_W-1:0];
    r.uv   = uv[UV_W-1:0];
    r.ph   = ph[PH_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] noisy_code(input int center);
    int v;
    if ($urandom_range(0, 5) == 0) return SAMPLE_W'($urandom);
    v = center + int'($urandom_range(0, 400)) - 200;
    if (v > 32767) v = 32767;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic drop_in();
    if (in_busy) begin
      in_valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  task automatic drop_cfg();
    if (cfg_busy) begin
      cfg_valid <= 1'b0;
      cfg_busy = 1'b0;
    end
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain();
    drop_in();
    while (pending_ph.size() != 0) @(negedge clk);
  endtask

  // Entered and left just after a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_busy = 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_writes++;
    unique case (idx)
      REG_VREF:   vref_mv_m    = data[VREF_W-1:0];
      REG_FS:     full_scale_m = data[FS_W-1:0];
      REG_CAL4:   cal4_m       = data;
      REG_CAL686: cal686_m     = data;
      REG_CAL9:   cal9_m       = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    ph_result_t r;
    drop_cfg();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      drop_in();
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_busy = 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_samples++;
    if (gather_code(s, r)) begin
      if (use_typed) begin
        pending_ph.push_back(typed_want);
        use_typed = 1'b0;
      end else begin
        pending_ph.push_back(r);
      end
    end
    @(negedge clk);
  endtask

  task automatic setup_phase(input int p);
    logic [VREF_W-1:0] vr;
    logic [FS_W-1:0]   fs;
    longint top, fsd, ctop, t;
    longint c [3];
    case (p)
      0: begin vr = VREF_RST; fs = FS_RST; end
      1: begin vr = 13'd6000; fs = 16'hFFFF; end
      2: begin vr = 13'd1;    fs = 16'd1; end
      3: begin vr = 13'h1FFF; fs = 16'd0; end
      4: begin vr = 13'd0;    fs = FS_W'($urandom_range(1, 65535)); end
      default: begin
        vr = VREF_W'($urandom_range(1, 6000));
        fs = FS_W'($urandom_range(1, 65535));
      end
    endcase
    fsd = (fs == 0) ? 1 : longint'(fs);
    top = 32767 * longint'(vr) * 1000 / fsd;
    if (top > UV_SAT) top = UV_SAT;
    if (top < 3) top = UV_SAT;
    // keep group means where the voltage is not pinned at saturation
    if (vr == 0) ctop = 32767;
    else ctop = UV_SAT * fsd / (longint'(vr) * 1000) + 1;
    if (ctop > 32767) ctop = 32767;
    center_top = int'(ctop);

    for (int i = 0; i < 3; i++) c[i] = $urandom_range(1, int'(top));
    for (int i = 0; i < 3; i++)
      for (int j = i + 1; j < 3; j++)
        if (c[i] > c[j]) begin
          t = c[i];
          c[i] = c[j];
          c[j] = t;
        end
    if (p == 5) c[$urandom_range(0, 2)] = 0;
    if (p == 6) c[1] = $urandom_range(0, 1) ? c[0] : c[2];
    if (p == 7)
      for (int i = 0; i < 3; i++) c[i] = $urandom & 32'h7FFFFF;

    write_reg(CFG_IDX_W'($urandom_range(IDX_FIRST_UNUSED, IDX_TOP_UNUSED)),
              CFG_DATA_W'($urandom));
    write_reg(REG_VREF, CFG_DATA_W'(vr));
    write_reg(REG_FS, CFG_DATA_W'(fs));
    write_reg(REG_CAL4, c[0][UV_W-1:0]);
    write_reg(REG_CAL686, c[1][UV_W-1:0]);
    write_reg(REG_CAL9, c[2][UV_W-1:0]);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    ph_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ph.size() == 0) begin
        $error("unexpected result transfer: mean_code %0d", out_mean_code);
        fail_count++;
      end else begin
        want = pending_ph.pop_front();
        n_checked++;
        if (out_mean_code !== want.mean) begin
          $error("mean_code: expected %0d, got %0d", want.mean, out_mean_code);
          fail_count++;
        end
        if (out_voltage_uv !== want.uv) begin
          $error("voltage_uv: expected %0d, got %0d", want.uv, out_voltage_uv);
          fail_count++;
        end
        if (out_ph_milli !== want.ph) begin
          $error("ph_milli: expected %0d, got %0d", want.ph, out_ph_milli);
          fail_count++;
        end
        if (out_status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_status);
          fail_count++;
        end
      end
    end
  end

  // Abort when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** ph_trimmed_mean_calibrator: FAILED **");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    center_top = 32767;
    idle_cycles = 0;
    vref_mv_m = VREF_RST;
    full_scale_m = FS_RST;
    cal4_m = '0;
    cal686_m = '0;
    cal9_m = '0;
    grp_codes = '{default: '0};
    grp_fill = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NROWS; r++) begin
      if (DIR_ROWS[r].is_cfg) begin
        drain();
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
      end else begin
        use_typed = DIR_ROWS[r].typed;
        typed_want = DIR_ROWS[r].want;
        for (int k = 0; k < 4; k++) push_sample(DIR_ROWS[r].smp[k]);
      end
    end
    // reversed low line with a span of minus one: pH pinned at the top
    use_typed = 1'b1;
    typed_want = '{15'd0, 23'd0, 18'sd100000, STAT_OK};
    for (int k = 0; k < 4; k++) push_sample('0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      setup_phase(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int g = 0; g < GROUPS_PER_PHASE; g++) begin : one_group
        int center;
        center = $urandom_range(0, center_top);
        for (int k = 0; k < 4; k++) push_sample(noisy_code(center));
      end
    end

    drop_cfg();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_ph.size() != 0) begin
      $error("%0d results never arrived", pending_ph.size());
      fail_count++;
    end
    $display("Sent %0d samples, checked %0d group results, %0d register writes",
             n_samples, n_checked, n_writes);
    $display("Covered clamping, saturation, uncalibrated and degenerate spans");
    if (fail_count == 0) begin
      $display("** ph_trimmed_mean_calibrator: PASSED **");
    end else begin
      $display("** ph_trimmed_mean_calibrator: FAILED **");
    end
    $finish;
  end

endmodule
